@@ src/shgc_pkg.sv @@
// Shared constants for the stereo high-pass / low-pass / gain chain.
// Used by the channel interfaces and the top level; no dependencies.

package shgc_pkg;

  // Sample and register widths
  localparam int SAMPLE_W      = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 5;
  localparam int FRAC_BITS_DEF = 16;

  // High-pass alphas 1/(1+2*pi*fc/44100), 24 fraction bits, floored
  localparam logic [31:0] HP_ALPHA_20_Q24 = 32'd16729544;
  localparam logic [31:0] HP_ALPHA_90_Q24 = 32'd16564808;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_HPF_MODE   = 3'd0;
  localparam logic [2:0] REG_LPF_ENABLE = 3'd1;
  localparam logic [2:0] REG_LPF_ALPHA  = 3'd2;
  localparam logic [2:0] REG_GAIN       = 3'd3;
  localparam logic [2:0] REG_MUTE       = 3'd4;

  // High-pass mode codes
  localparam logic [1:0] HPF_OFF = 2'd0;
  localparam logic [1:0] HPF_20  = 2'd1;

endpackage

@@ src/shgc_in_if.sv @@
// Input frame channel: valid/ready handshake with a stereo sample payload.
// Depends on shgc_pkg for the sample width.

interface shgc_in_if import shgc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  logic                       voice_active;
  logic                       block_end;

  modport source (output valid, left_in, right_in, voice_active, block_end, input ready);
  modport sink   (input valid, left_in, right_in, voice_active, block_end, output ready);
endinterface

@@ src/shgc_out_if.sv @@
// Result frame channel: valid/ready handshake with the processed stereo payload.
// Depends on shgc_pkg for the sample width.

interface shgc_out_if import shgc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       block_end_out;

  modport source (output valid, left_out, right_out, block_end_out, input ready);
  modport sink   (input valid, left_out, right_out, block_end_out, output ready);
endinterface

@@ src/stereo_hpf_lpf_gain_chain.sv @@
// Top level of the stereo one-pole high-pass, low-pass and gain chain.
// Depends on shgc_pkg, shgc_in_if and shgc_out_if.
//
//   Port        Direction  Purpose
//   in_s        sink       stereo frame in, voice flag, block end mark
//   out_m       source     processed stereo frame, block end copy
//   cfg_*       APB slave  hpf_mode, lpf_enable, lpf_alpha, gain, mute
//
// One signed 32x32 multiplier with a registered product serves every step.
// A silent or muted frame skips the filter and gain steps and yields zeros; an active
// frame runs the enabled high-pass and low-pass steps and then gain, left channel first.
// in_s.ready is high only while the sequencer is idle; a finished result waits
// in the output register and a stalled output holds the sequencer before it.
// rst_n is synchronous, active low; filter state resets to zero.

module stereo_hpf_lpf_gain_chain import shgc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  shgc_in_if.sink               in_s,
  shgc_out_if.source            out_m,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [31:0] ONE_FX  = 32'(1) << FRAC_BITS;
  localparam logic [31:0] HP_A20  = HP_ALPHA_20_Q24 >> (24 - FRAC_BITS);
  localparam logic [31:0] HP_A90  = HP_ALPHA_90_Q24 >> (24 - FRAC_BITS);
  localparam logic [17:0] GAIN_RST = ONE_FX[17:0];

  typedef enum logic [3:0] {
    S_IDLE, S_HP, S_HPW, S_LPA, S_LPB, S_LPW, S_GAIN, S_GW, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   ch_r, ch_nxt;

  // Configuration registers
  logic [1:0]  hpf_mode_r, hpf_mode_nxt;
  logic        lpf_en_r, lpf_en_nxt;
  logic [16:0] lpf_alpha_r, lpf_alpha_nxt;
  logic [17:0] gain_r, gain_nxt;
  logic        mute_r, mute_nxt;

  // Filter state, index 0 left, 1 right
  logic [31:0] hp_in_r [2];
  logic [31:0] hp_in_nxt [2];
  logic [31:0] hp_out_r [2];
  logic [31:0] hp_out_nxt [2];
  logic [31:0] lp_r [2];
  logic [31:0] lp_nxt [2];

  // Working registers
  logic [31:0] xr_r, xr_nxt;
  logic [31:0] s_r, s_nxt;
  logic [31:0] t_r, t_nxt;
  logic [31:0] res_r [2];
  logic [31:0] res_nxt [2];
  logic        be_r, be_nxt;
  logic signed [63:0] prod_r, prod_nxt;

  // Output register
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] oleft_r, oleft_nxt;
  logic [31:0] oright_r, oright_nxt;
  logic        obe_r, obe_nxt;

  // Shared multiplier operands and scaled product
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_sh;
  logic [31:0]        fx;
  logic [31:0]        hp_alpha;
  logic [31:0]        lp_om;
  logic [31:0]        lp_y;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  state_t             first_stage;

  assign prod_sh  = prod_r >>> FRAC_BITS;
  assign fx       = prod_sh[31:0];
  assign prod_nxt = mul_a * mul_b;
  assign hp_alpha = (hpf_mode_r == HPF_20) ? HP_A20 : HP_A90;
  assign lp_om    = ONE_FX - {15'd0, lpf_alpha_r};
  assign lp_y     = t_r + fx;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  assign in_s.ready          = (state_r == S_IDLE);
  assign out_m.valid         = ovalid_r;
  assign out_m.left_out      = oleft_r;
  assign out_m.right_out     = oright_r;
  assign out_m.block_end_out = obe_r;

  // Register read-back
  always_comb begin
    case (cfg_idx)
      REG_HPF_MODE:   cfg_prdata = {30'd0, hpf_mode_r};
      REG_LPF_ENABLE: cfg_prdata = {31'd0, lpf_en_r};
      REG_LPF_ALPHA:  cfg_prdata = {15'd0, lpf_alpha_r};
      REG_GAIN:       cfg_prdata = {14'd0, gain_r};
      REG_MUTE:       cfg_prdata = {31'd0, mute_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // First step of each channel
  always_comb begin
    if (hpf_mode_r != HPF_OFF) begin
      first_stage = S_HP;
    end else if (lpf_en_r) begin
      first_stage = S_LPA;
    end else begin
      first_stage = S_GAIN;
    end
  end

  // Sequencer, configuration and datapath next values
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    hpf_mode_nxt  = hpf_mode_r;
    lpf_en_nxt    = lpf_en_r;
    lpf_alpha_nxt = lpf_alpha_r;
    gain_nxt      = gain_r;
    mute_nxt      = mute_r;
    hp_in_nxt     = hp_in_r;
    hp_out_nxt    = hp_out_r;
    lp_nxt        = lp_r;
    xr_nxt        = xr_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    res_nxt       = res_r;
    be_nxt        = be_r;
    ovalid_nxt    = ovalid_r;
    oleft_nxt     = oleft_r;
    oright_nxt    = oright_r;
    obe_nxt       = obe_r;
    mul_a         = '0;
    mul_b         = '0;

    // Drop the output once transferred
    if (ovalid_r && out_m.ready) begin
      ovalid_nxt = 1'b0;
    end

    // Register writes; filter settings clear their filter's state
    if (cfg_wr) begin
      case (cfg_idx)
        REG_HPF_MODE: begin
          hpf_mode_nxt = cfg_pwdata[1:0];
          hp_in_nxt    = '{default: '0};
          hp_out_nxt   = '{default: '0};
        end
        REG_LPF_ENABLE: begin
          lpf_en_nxt = cfg_pwdata[0];
          lp_nxt     = '{default: '0};
        end
        REG_LPF_ALPHA: begin
          lpf_alpha_nxt = cfg_pwdata[16:0];
          lp_nxt        = '{default: '0};
        end
        REG_GAIN: gain_nxt = cfg_pwdata[17:0];
        REG_MUTE: mute_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_s.valid) begin
          be_nxt = in_s.block_end;
          xr_nxt = in_s.right_in;
          s_nxt  = in_s.left_in;
          ch_nxt = 1'b0;
          if (!in_s.voice_active || mute_r) begin
            res_nxt   = '{default: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = first_stage;
          end
        end
      end
      S_HP: begin
        mul_a     = hp_alpha;
        mul_b     = hp_out_r[ch_r] + (s_r - hp_in_r[ch_r]);
        state_nxt = S_HPW;
      end
      S_HPW: begin
        hp_in_nxt[ch_r]  = s_r;
        hp_out_nxt[ch_r] = fx;
        s_nxt            = fx;
        state_nxt        = lpf_en_r ? S_LPA : S_GAIN;
      end
      S_LPA: begin
        mul_a     = {15'd0, lpf_alpha_r};
        mul_b     = s_r;
        state_nxt = S_LPB;
      end
      S_LPB: begin
        t_nxt     = fx;
        mul_a     = lp_om;
        mul_b     = lp_r[ch_r];
        state_nxt = S_LPW;
      end
      S_LPW: begin
        lp_nxt[ch_r] = lp_y;
        s_nxt        = lp_y;
        state_nxt    = S_GAIN;
      end
      S_GAIN: begin
        mul_a     = s_r;
        mul_b     = {14'd0, gain_r};
        state_nxt = S_GW;
      end
      S_GW: begin
        res_nxt[ch_r] = fx;
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          s_nxt     = xr_r;
          state_nxt = first_stage;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!ovalid_r || out_m.ready) begin
          ovalid_nxt = 1'b1;
          oleft_nxt  = res_r[0];
          oright_nxt = res_r[1];
          obe_nxt    = be_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, configuration, filter state, working and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      hpf_mode_r  <= HPF_OFF;
      lpf_en_r    <= 1'b0;
      lpf_alpha_r <= '0;
      gain_r      <= GAIN_RST;
      mute_r      <= 1'b0;
      hp_in_r     <= '{default: '0};
      hp_out_r    <= '{default: '0};
      lp_r        <= '{default: '0};
      ovalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      hpf_mode_r  <= hpf_mode_nxt;
      lpf_en_r    <= lpf_en_nxt;
      lpf_alpha_r <= lpf_alpha_nxt;
      gain_r      <= gain_nxt;
      mute_r      <= mute_nxt;
      hp_in_r     <= hp_in_nxt;
      hp_out_r    <= hp_out_nxt;
      lp_r        <= lp_nxt;
      ovalid_r    <= ovalid_nxt;
    end
    xr_r     <= xr_nxt;
    s_r      <= s_nxt;
    t_r      <= t_nxt;
    res_r    <= res_nxt;
    be_r     <= be_nxt;
    prod_r   <= prod_nxt;
    oleft_r  <= oleft_nxt;
    oright_r <= oright_nxt;
    obe_r    <= obe_nxt;
  end

endmodule
